/* hw/rtl/assert_macros.svh */
// assertion macros used by pl0rpm_back
// depends on nothing; an assertion reports through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define A_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");
`define A_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define A_HOLDS(lbl, clk, rstn, prop)
`define A_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* hw/rtl/pl0rpm_pkg.sv */
// shared types and constants of the register p-machine executor
// used by every module of the block
`default_nettype none
package pl0rpm_pkg;
    localparam int SA_W        = 10;
    localparam int STACK_DEPTH = 2 ** SA_W;
    localparam int PTR_W       = 11;
    localparam int PC_W        = 9;
    localparam int RI_W        = 3;
    localparam int REG_COUNT   = 2 ** RI_W;
    localparam int DIV_STEPS   = 32;
    localparam int DCNT_W      = 5;

    localparam logic [31:0] SYS_WRITE = 32'd1;
    localparam logic [31:0] SYS_READ  = 32'd2;
    localparam logic [31:0] SYS_HALT  = 32'd3;

    typedef enum logic [4:0] {
        OP_NOP = 5'd0,  OP_LIT = 5'd1,  OP_RTN = 5'd2,  OP_LOD = 5'd3,
        OP_STO = 5'd4,  OP_CAL = 5'd5,  OP_INC = 5'd6,  OP_JMP = 5'd7,
        OP_JPC = 5'd8,  OP_SYS = 5'd9,  OP_NEG = 5'd10, OP_ADD = 5'd11,
        OP_SUB = 5'd12, OP_MUL = 5'd13, OP_DIV = 5'd14, OP_ODD = 5'd15,
        OP_MOD = 5'd16, OP_EQL = 5'd17, OP_NEQ = 5'd18, OP_LSS = 5'd19,
        OP_LEQ = 5'd20, OP_GTR = 5'd21, OP_GEQ = 5'd22
    } t_op;

    typedef enum logic [1:0] {
        FLT_NONE  = 2'd0,
        FLT_DIV0  = 2'd1,
        FLT_RANGE = 2'd2
    } t_flt;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_RDA, ST_RDB, ST_RDR, ST_EXE, ST_WLK, ST_WCHK,
        ST_ADR, ST_LD1, ST_LD2, ST_STO, ST_CL1, ST_CL2, ST_CL3, ST_RT1,
        ST_RT2, ST_RT3, ST_DIVW, ST_FIN
    } t_bst;

    typedef struct packed {
        logic [4:0]         opcode;
        logic [2:0]         reg_sel;
        logic [3:0]         level_or_src;
        logic signed [31:0] operand_m;
        logic signed [31:0] read_value;
    } t_in;

    typedef struct packed {
        logic [8:0]         next_pc;
        logic [10:0]        base_ptr;
        logic [10:0]        stack_ptr;
        logic               print_valid;
        logic [2:0]         print_reg;
        logic signed [31:0] print_value;
        logic               read_taken;
        logic               halted;
        logic [1:0]         fault;
    } t_out;

    typedef struct packed {
        t_op         op;
        logic [2:0]  rs;
        logic [3:0]  lvl;
        logic [31:0] m;
        logic [31:0] rd;
    } t_qent;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_qctl;
endpackage
`default_nettype wire

/* hw/rtl/pl0rpm_div.sv */
// iterative signed divider, one quotient bit per cycle
// depends on pl0rpm_pkg
`default_nettype none
module pl0rpm_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot,
    output logic [31:0]      o_rem
);
    logic                                r_busy;
    logic                                r_fin;
    logic [pl0rpm_pkg::DCNT_W-1:0]       r_cnt;
    logic [31:0]                         r_rem;
    logic [31:0]                         r_quo;
    logic [31:0]                         r_dv;
    logic                                r_sq;
    logic                                r_sr;
    logic [32:0]                         shifted;
    logic [32:0]                         trial;

    assign shifted = {r_rem, r_quo[31]};
    assign trial   = shifted - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pl0rpm_pkg::DCNT_W'(pl0rpm_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_dv  <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_sq  <= i_dividend[31] ^ i_divisor[31];
            r_sr  <= i_dividend[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= shifted[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_fin;
    assign o_quot = r_sq ? (32'd0 - r_quo) : r_quo;
    assign o_rem  = r_sr ? (32'd0 - r_rem) : r_rem;
endmodule
`default_nettype wire

/* hw/rtl/pl0rpm_front.sv */
// front end: accepts instruction words, decodes the opcode, two-entry queue
// depends on pl0rpm_pkg
`default_nettype none
module pl0rpm_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire pl0rpm_pkg::t_in   i_in,
    input  wire pl0rpm_pkg::t_qctl i_ctl,
    output logic                   o_q_valid,
    output pl0rpm_pkg::t_qent      o_q
);
    pl0rpm_pkg::t_qent r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              push;
    logic              pop;
    pl0rpm_pkg::t_qent dec;

    // unknown opcodes become a no-op
    always_comb begin
        dec.op = pl0rpm_pkg::OP_NOP;
        if (i_in.opcode >= 5'd1 && i_in.opcode <= 5'd22) begin
            dec.op = pl0rpm_pkg::t_op'(i_in.opcode);
        end
        dec.rs  = i_in.reg_sel;
        dec.lvl = i_in.level_or_src;
        dec.m   = i_in.operand_m;
        dec.rd  = i_in.read_value;
    end

    assign o_in_stall = (r_cnt == 2'd2) || i_ctl.clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_ctl.pop && (r_cnt != 2'd0);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= dec;
    end
endmodule
`default_nettype wire

/* hw/rtl/pl0rpm_back.sv */
// back end: register file, stack memory and the execute sequencer
// depends on pl0rpm_pkg, pl0rpm_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pl0rpm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire pl0rpm_pkg::t_qent i_q,
    output pl0rpm_pkg::t_qctl      o_ctl,
    input  wire logic              i_out_free,
    output logic                   o_res_load,
    output pl0rpm_pkg::t_out       o_res
);
    localparam int SA_W  = pl0rpm_pkg::SA_W;
    localparam int PTR_W = pl0rpm_pkg::PTR_W;
    localparam int PC_W  = pl0rpm_pkg::PC_W;
    localparam int RI_W  = pl0rpm_pkg::RI_W;

    logic [31:0] r_regs [pl0rpm_pkg::REG_COUNT];
    logic [31:0] r_stk  [pl0rpm_pkg::STACK_DEPTH];
    logic [31:0] r_rg_q;
    logic [31:0] r_sk_q;

    pl0rpm_pkg::t_bst  r_st, n_st;
    logic [SA_W-1:0]   r_clr, n_clr;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [PTR_W-1:0]  r_bp, n_bp;
    logic [PTR_W-1:0]  r_sp, n_sp;
    logic              r_halt, n_halt;
    logic              r_wr, n_wr;
    logic              r_pv, n_pv;
    logic              r_rt, n_rt;
    pl0rpm_pkg::t_flt  r_flt, n_flt;
    pl0rpm_pkg::t_qent r_it, n_it;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_b, n_b;
    logic [31:0]       r_r, n_r;
    logic [31:0]       r_res, n_res;
    logic [31:0]       r_tmp, n_tmp;
    logic [3:0]        r_lvl, n_lvl;
    logic [SA_W-1:0]   r_base, n_base;
    logic [SA_W-1:0]   r_addr, n_addr;

    logic              rg_we;
    logic [RI_W-1:0]   rg_wa;
    logic [RI_W-1:0]   rg_ra;
    logic [31:0]       rg_wd;
    logic              sk_we;
    logic [SA_W-1:0]   sk_a;
    logic [31:0]       sk_wd;
    logic              q_pop;
    logic              div_start;
    logic              div_done;
    logic [31:0]       div_q;
    logic [31:0]       div_r;
    logic [33:0]       inc_addr;
    logic [33:0]       ls_addr;
    logic [PTR_W-1:0]  bp_m1, bp_m2, sp_m1, sp_m2, sp_m3;

    pl0rpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    assign inc_addr = {{(34-PTR_W){1'b0}}, r_sp} - {{2{r_it.m[31]}}, r_it.m};
    assign ls_addr  = {{(34-SA_W){1'b0}}, r_base} - {{2{r_it.m[31]}}, r_it.m};
    assign bp_m1    = r_bp - PTR_W'(1);
    assign bp_m2    = r_bp - PTR_W'(2);
    assign sp_m1    = r_sp - PTR_W'(1);
    assign sp_m2    = r_sp - PTR_W'(2);
    assign sp_m3    = r_sp - PTR_W'(3);

    always_comb begin
        n_st = r_st;   n_clr = r_clr;  n_pc = r_pc;     n_bp = r_bp;
        n_sp = r_sp;   n_halt = r_halt; n_wr = r_wr;    n_pv = r_pv;
        n_rt = r_rt;   n_flt = r_flt;  n_it = r_it;     n_a = r_a;
        n_b = r_b;     n_r = r_r;      n_res = r_res;   n_tmp = r_tmp;
        n_lvl = r_lvl; n_base = r_base; n_addr = r_addr;
        rg_we = 1'b0;  rg_wa = r_it.rs; rg_wd = r_res;  rg_ra = r_it.rs;
        sk_we = 1'b0;  sk_a = r_addr;  sk_wd = r_r;
        q_pop = 1'b0;  div_start = 1'b0; o_res_load = 1'b0;
        case (r_st)
            pl0rpm_pkg::ST_CLR: begin
                sk_we = 1'b1;
                sk_a  = r_clr;
                sk_wd = '0;
                rg_we = 1'b1;
                rg_wa = r_clr[RI_W-1:0];
                rg_wd = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == {SA_W{1'b1}}) n_st = pl0rpm_pkg::ST_IDLE;
            end
            pl0rpm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    q_pop = 1'b1;
                    n_it  = i_q;
                    n_pv  = 1'b0;
                    n_rt  = 1'b0;
                    n_wr  = 1'b0;
                    n_flt = pl0rpm_pkg::FLT_NONE;
                    n_st  = r_halt ? pl0rpm_pkg::ST_FIN : pl0rpm_pkg::ST_RDA;
                end
            end
            pl0rpm_pkg::ST_RDA: begin
                rg_ra = r_it.lvl[RI_W-1:0];
                n_pc  = r_pc + 1'b1;
                n_st  = pl0rpm_pkg::ST_RDB;
            end
            pl0rpm_pkg::ST_RDB: begin
                rg_ra = r_it.m[RI_W-1:0];
                n_a   = r_rg_q;
                n_st  = pl0rpm_pkg::ST_RDR;
            end
            pl0rpm_pkg::ST_RDR: begin
                n_b  = r_rg_q;
                n_st = pl0rpm_pkg::ST_EXE;
            end
            pl0rpm_pkg::ST_EXE: begin
                n_r  = r_rg_q;
                n_st = pl0rpm_pkg::ST_FIN;
                case (r_it.op)
                    pl0rpm_pkg::OP_LIT: begin n_res = r_it.m; n_wr = 1'b1; end
                    pl0rpm_pkg::OP_RTN: begin
                        if (r_bp < PTR_W'(2)) n_flt = pl0rpm_pkg::FLT_RANGE;
                        else n_st = pl0rpm_pkg::ST_RT1;
                    end
                    pl0rpm_pkg::OP_LOD, pl0rpm_pkg::OP_STO, pl0rpm_pkg::OP_CAL: begin
                        if (r_bp >= PTR_W'(pl0rpm_pkg::STACK_DEPTH) ||
                            (r_it.op == pl0rpm_pkg::OP_CAL &&
                             (r_sp < PTR_W'(3) ||
                              r_sp > PTR_W'(pl0rpm_pkg::STACK_DEPTH)))) begin
                            n_flt = pl0rpm_pkg::FLT_RANGE;
                        end else begin
                            n_base = r_bp[SA_W-1:0];
                            n_lvl  = r_it.lvl;
                            n_st   = pl0rpm_pkg::ST_WLK;
                        end
                    end
                    pl0rpm_pkg::OP_INC: begin
                        if (inc_addr > 34'(pl0rpm_pkg::STACK_DEPTH))
                            n_flt = pl0rpm_pkg::FLT_RANGE;
                        else n_sp = inc_addr[PTR_W-1:0];
                    end
                    pl0rpm_pkg::OP_JMP: n_pc = r_it.m[PC_W-1:0];
                    pl0rpm_pkg::OP_JPC: if (r_rg_q == '0) n_pc = r_it.m[PC_W-1:0];
                    pl0rpm_pkg::OP_SYS: begin
                        if (r_it.m == pl0rpm_pkg::SYS_WRITE) begin
                            n_pv = 1'b1;
                        end else if (r_it.m == pl0rpm_pkg::SYS_READ) begin
                            n_res = r_it.rd;
                            n_wr  = 1'b1;
                            n_rt  = 1'b1;
                        end else if (r_it.m == pl0rpm_pkg::SYS_HALT) begin
                            n_halt = 1'b1;
                        end
                    end
                    pl0rpm_pkg::OP_NEG: begin n_res = 32'd0 - r_rg_q; n_wr = 1'b1; end
                    pl0rpm_pkg::OP_ODD: begin
                        // remainder keeps the sign of the value
                        n_res = !r_rg_q[0] ? 32'd0 : (r_rg_q[31] ? '1 : 32'd1);
                        n_wr  = 1'b1;
                    end
                    pl0rpm_pkg::OP_ADD: begin n_res = r_a + r_b; n_wr = 1'b1; end
                    pl0rpm_pkg::OP_SUB: begin n_res = r_a - r_b; n_wr = 1'b1; end
                    pl0rpm_pkg::OP_MUL: begin n_res = r_a * r_b; n_wr = 1'b1; end
                    pl0rpm_pkg::OP_DIV, pl0rpm_pkg::OP_MOD: begin
                        if (r_b == '0) begin
                            n_flt = pl0rpm_pkg::FLT_DIV0;
                        end else begin
                            div_start = 1'b1;
                            n_st      = pl0rpm_pkg::ST_DIVW;
                        end
                    end
                    pl0rpm_pkg::OP_EQL: begin
                        n_res = {31'd0, r_a == r_b}; n_wr = 1'b1;
                    end
                    pl0rpm_pkg::OP_NEQ: begin
                        n_res = {31'd0, r_a != r_b}; n_wr = 1'b1;
                    end
                    pl0rpm_pkg::OP_LSS: begin
                        n_res = {31'd0, $signed(r_a) < $signed(r_b)};  n_wr = 1'b1;
                    end
                    pl0rpm_pkg::OP_LEQ: begin
                        n_res = {31'd0, $signed(r_a) <= $signed(r_b)}; n_wr = 1'b1;
                    end
                    pl0rpm_pkg::OP_GTR: begin
                        n_res = {31'd0, $signed(r_a) > $signed(r_b)};  n_wr = 1'b1;
                    end
                    pl0rpm_pkg::OP_GEQ: begin
                        n_res = {31'd0, $signed(r_a) >= $signed(r_b)}; n_wr = 1'b1;
                    end
                    default: ;
                endcase
            end
            pl0rpm_pkg::ST_WLK: begin
                // follow one static link per pass through ST_WLK and ST_WCHK
                sk_a = r_base;
                if (r_lvl == 4'd0) n_st = pl0rpm_pkg::ST_ADR;
                else n_st = pl0rpm_pkg::ST_WCHK;
            end
            pl0rpm_pkg::ST_WCHK: begin
                if (r_sk_q[31:SA_W] == '0) begin
                    n_base = r_sk_q[SA_W-1:0];
                    n_lvl  = r_lvl - 4'd1;
                    n_st   = pl0rpm_pkg::ST_WLK;
                end else begin
                    n_flt = pl0rpm_pkg::FLT_RANGE;
                    n_st  = pl0rpm_pkg::ST_FIN;
                end
            end
            pl0rpm_pkg::ST_ADR: begin
                n_addr = ls_addr[SA_W-1:0];
                if (r_it.op == pl0rpm_pkg::OP_CAL) begin
                    n_st = pl0rpm_pkg::ST_CL1;
                end else if (ls_addr >= 34'(pl0rpm_pkg::STACK_DEPTH)) begin
                    n_flt = pl0rpm_pkg::FLT_RANGE;
                    n_st  = pl0rpm_pkg::ST_FIN;
                end else if (r_it.op == pl0rpm_pkg::OP_LOD) begin
                    n_st = pl0rpm_pkg::ST_LD1;
                end else begin
                    n_st = pl0rpm_pkg::ST_STO;
                end
            end
            pl0rpm_pkg::ST_LD1: begin
                sk_a = r_addr;
                n_st = pl0rpm_pkg::ST_LD2;
            end
            pl0rpm_pkg::ST_LD2: begin
                n_res = r_sk_q;
                n_wr  = 1'b1;
                n_st  = pl0rpm_pkg::ST_FIN;
            end
            pl0rpm_pkg::ST_STO: begin
                sk_we = 1'b1;
                sk_a  = r_addr;
                sk_wd = r_r;
                n_st  = pl0rpm_pkg::ST_FIN;
            end
            pl0rpm_pkg::ST_CL1: begin
                sk_we = 1'b1;
                sk_a  = sp_m1[SA_W-1:0];
                sk_wd = {{(32-SA_W){1'b0}}, r_base};
                n_st  = pl0rpm_pkg::ST_CL2;
            end
            pl0rpm_pkg::ST_CL2: begin
                sk_we = 1'b1;
                sk_a  = sp_m2[SA_W-1:0];
                sk_wd = {{(32-PTR_W){1'b0}}, r_bp};
                n_st  = pl0rpm_pkg::ST_CL3;
            end
            pl0rpm_pkg::ST_CL3: begin
                sk_we = 1'b1;
                sk_a  = sp_m3[SA_W-1:0];
                sk_wd = {{(32-PC_W){1'b0}}, r_pc};
                n_bp  = sp_m1;
                n_pc  = r_it.m[PC_W-1:0];
                n_st  = pl0rpm_pkg::ST_FIN;
            end
            pl0rpm_pkg::ST_RT1: begin
                sk_a = bp_m1[SA_W-1:0];
                n_st = pl0rpm_pkg::ST_RT2;
            end
            pl0rpm_pkg::ST_RT2: begin
                sk_a  = bp_m2[SA_W-1:0];
                n_tmp = r_sk_q;
                n_st  = pl0rpm_pkg::ST_RT3;
            end
            pl0rpm_pkg::ST_RT3: begin
                if (r_tmp[31:SA_W] != '0) begin
                    n_flt = pl0rpm_pkg::FLT_RANGE;
                end else begin
                    n_sp = r_bp + PTR_W'(1);
                    n_pc = r_sk_q[PC_W-1:0];
                    n_bp = {1'b0, r_tmp[SA_W-1:0]};
                end
                n_st = pl0rpm_pkg::ST_FIN;
            end
            pl0rpm_pkg::ST_DIVW: begin
                if (div_done) begin
                    n_res = (r_it.op == pl0rpm_pkg::OP_DIV) ? div_q : div_r;
                    n_wr  = 1'b1;
                    n_st  = pl0rpm_pkg::ST_FIN;
                end
            end
            pl0rpm_pkg::ST_FIN: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    rg_we      = r_wr;
                    n_st       = pl0rpm_pkg::ST_IDLE;
                end
            end
            default: n_st = pl0rpm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_res.next_pc     = r_pc;
        o_res.base_ptr    = r_bp;
        o_res.stack_ptr   = r_sp;
        o_res.print_valid = r_pv;
        o_res.print_reg   = r_pv ? r_it.rs : '0;
        o_res.print_value = r_pv ? r_r : '0;
        o_res.read_taken  = r_rt;
        o_res.halted      = r_halt;
        o_res.fault       = r_flt;
    end

    assign o_ctl.pop      = q_pop;
    assign o_ctl.clearing = (r_st == pl0rpm_pkg::ST_CLR);

    always_ff @(posedge i_clk) begin
        if (rg_we) r_regs[rg_wa] <= rg_wd;
        r_rg_q <= r_regs[rg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sk_we) r_stk[sk_a] <= sk_wd;
        r_sk_q <= r_stk[sk_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= pl0rpm_pkg::ST_CLR;
            r_clr  <= '0;
            r_pc   <= '0;
            r_bp   <= PTR_W'(pl0rpm_pkg::STACK_DEPTH - 1);
            r_sp   <= PTR_W'(pl0rpm_pkg::STACK_DEPTH);
            r_halt <= 1'b0;
            r_wr   <= 1'b0;
            r_pv   <= 1'b0;
            r_rt   <= 1'b0;
            r_flt  <= pl0rpm_pkg::FLT_NONE;
        end else begin
            r_st   <= n_st;
            r_clr  <= n_clr;
            r_pc   <= n_pc;
            r_bp   <= n_bp;
            r_sp   <= n_sp;
            r_halt <= n_halt;
            r_wr   <= n_wr;
            r_pv   <= n_pv;
            r_rt   <= n_rt;
            r_flt  <= n_flt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it   <= n_it;
        r_a    <= n_a;
        r_b    <= n_b;
        r_r    <= n_r;
        r_res  <= n_res;
        r_tmp  <= n_tmp;
        r_lvl  <= n_lvl;
        r_base <= n_base;
        r_addr <= n_addr;
    end

    `A_HOLDS(a_load_free, i_clk, i_rst_n, o_res_load |-> i_out_free)
    `A_HOLDS(a_sp_range, i_clk, i_rst_n, r_sp <= PTR_W'(pl0rpm_pkg::STACK_DEPTH))
    `A_HOLDS(a_div_fault, i_clk, i_rst_n, (o_res_load && r_flt == pl0rpm_pkg::FLT_DIV0) |-> (r_it.op == pl0rpm_pkg::OP_DIV || r_it.op == pl0rpm_pkg::OP_MOD))
    `A_NEVER(a_pop_clear, i_clk, i_rst_n, q_pop && o_ctl.clearing)
endmodule
`default_nettype wire

/* hw/rtl/pl0_register_pmachine_execute.sv */
// Executes one instruction word of an eight-register pl/0 p-machine per input word and
// returns one result word holding the new pc, bp and sp, print/read info, halt and fault.
// After reset the stack memory and register file are swept to zero, during which no input
// word is taken. A two-entry queue lets the front accept words while the executor works.
// Per word the executor reads the registers, then executes; lod, sto and cal first follow
// the static links one level at a time (one stack memory port), and div and mod wait on the
// divider, which makes one quotient bit per cycle.
// Once halted, each word skips execution and returns the frozen state.
// depends on pl0rpm_pkg, pl0rpm_front, pl0rpm_back
`default_nettype none
module pl0_register_pmachine_execute (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // instruction words
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire pl0rpm_pkg::t_in i_in,
    // result words
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output pl0rpm_pkg::t_out     o_out
);
    pl0rpm_pkg::t_qctl ctl;
    pl0rpm_pkg::t_qent qent;
    logic              q_valid;
    logic              res_load;
    pl0rpm_pkg::t_out  res;
    logic              out_free;
    logic              r_out_valid;
    pl0rpm_pkg::t_out  r_out;

    // front: accept and decode into the queue
    pl0rpm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_ctl      (ctl),
        .o_q_valid  (q_valid),
        .o_q        (qent)
    );

    // back: state, memories and the execute sequencer
    pl0rpm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q        (qent),
        .o_ctl      (ctl),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) r_out <= res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
`default_nettype wire

/* dv/tb.sv */
// self-checking testbench of the register p-machine executor
// holds its own model of the machine in a small scoreboard class
// depends on pl0rpm_pkg and pl0_register_pmachine_execute
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import pl0rpm_pkg::*;

    localparam int CODE_DEPTH = 512;
    localparam int WDOG_LIMIT = 20000;   // must exceed the clearing pass and the longest instruction
    localparam int N_RANDOM   = 730;

    // machine model: state kept in step with the block
    class pmachine_board;
        logic [31:0] regs [REG_COUNT];
        logic [31:0] stk [STACK_DEPTH];
        logic [31:0] pc, bp, sp;
        bit          halted;
        t_out        pending [$];
        int          mismatches;
        int          checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (stk[i]) stk[i] = '0;
            pc = 0;
            bp = STACK_DEPTH - 1;
            sp = STACK_DEPTH;
            halted = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function bit addr_ok(longint a);
            return a >= 0 && a < STACK_DEPTH;
        endfunction

        // follow static links; returns 0 if any hop leaves the stack
        function bit walk_links(logic [3:0] lvl, output longint b);
            int k;
            b = longint'(bp);
            if (!addr_ok(b)) return 0;
            for (k = 0; k < lvl; k++) begin
                b = longint'($signed(stk[b]));
                if (!addr_ok(b)) return 0;
            end
            return 1;
        endfunction

        // execute one instruction word and queue the result it must produce
        function void note_word(t_in w);
            t_out   res;
            logic [31:0] s1, s2, mu;
            longint a, b, m, base, addr, nb;
            t_flt   flt;
            res = '0;
            flt = FLT_NONE;
            mu = w.operand_m;
            m = longint'(w.operand_m);
            s1 = regs[w.level_or_src[2:0]];
            s2 = regs[mu[2:0]];
            a = longint'($signed(s1));
            b = longint'($signed(s2));
            if (!halted) begin
                pc = (pc + 1) % CODE_DEPTH;
                case (w.opcode)
                    OP_LIT: regs[w.reg_sel] = mu;
                    OP_RTN: begin
                        if (bp < 2) flt = FLT_RANGE;
                        else begin
                            nb = longint'($signed(stk[bp - 1]));
                            if (!addr_ok(nb)) flt = FLT_RANGE;
                            else begin
                                sp = bp + 1;
                                pc = stk[bp - 2] % CODE_DEPTH;
                                bp = 32'(nb);
                            end
                        end
                    end
                    OP_LOD, OP_STO: begin
                        if (!walk_links(w.level_or_src, base)) flt = FLT_RANGE;
                        else begin
                            addr = base - m;
                            if (!addr_ok(addr)) flt = FLT_RANGE;
                            else if (w.opcode == OP_LOD) regs[w.reg_sel] = stk[addr];
                            else stk[addr] = regs[w.reg_sel];
                        end
                    end
                    OP_CAL: begin
                        if (sp < 3 || sp > STACK_DEPTH || !walk_links(w.level_or_src, base))
                            flt = FLT_RANGE;
                        else begin
                            stk[sp - 1] = 32'(base);
                            stk[sp - 2] = bp;
                            stk[sp - 3] = pc;
                            bp = sp - 1;
                            pc = mu % CODE_DEPTH;
                        end
                    end
                    OP_INC: begin
                        addr = longint'(sp) - m;
                        if (addr < 0 || addr > STACK_DEPTH) flt = FLT_RANGE;
                        else sp = 32'(addr);
                    end
                    OP_JMP: pc = mu % CODE_DEPTH;
                    OP_JPC: if (regs[w.reg_sel] == 0) pc = mu % CODE_DEPTH;
                    OP_SYS: begin
                        if (mu == SYS_WRITE) begin
                            res.print_valid = 1;
                            res.print_reg = w.reg_sel;
                            res.print_value = regs[w.reg_sel];
                        end else if (mu == SYS_READ) begin
                            regs[w.reg_sel] = w.read_value;
                            res.read_taken = 1;
                        end else if (mu == SYS_HALT) halted = 1;
                    end
                    OP_NEG: regs[w.reg_sel] = -regs[w.reg_sel];
                    OP_ADD: regs[w.reg_sel] = s1 + s2;
                    OP_SUB: regs[w.reg_sel] = s1 - s2;
                    OP_MUL: regs[w.reg_sel] = s1 * s2;
                    OP_DIV: if (b == 0) flt = FLT_DIV0; else regs[w.reg_sel] = 32'(a / b);
                    OP_ODD: regs[w.reg_sel] = 32'(longint'($signed(regs[w.reg_sel])) % 2);
                    OP_MOD: if (b == 0) flt = FLT_DIV0; else regs[w.reg_sel] = 32'(a % b);
                    OP_EQL: regs[w.reg_sel] = 32'(a == b);
                    OP_NEQ: regs[w.reg_sel] = 32'(a != b);
                    OP_LSS: regs[w.reg_sel] = 32'(a < b);
                    OP_LEQ: regs[w.reg_sel] = 32'(a <= b);
                    OP_GTR: regs[w.reg_sel] = 32'(a > b);
                    OP_GEQ: regs[w.reg_sel] = 32'(a >= b);
                    default: ;
                endcase
            end
            res.next_pc = pc[8:0];
            res.base_ptr = bp[10:0];
            res.stack_ptr = sp[10:0];
            res.halted = halted;
            res.fault = flt;
            pending.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out exp;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("tb: result word with nothing pending: %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch on result %0d\n  expected %p\n  actual   %p",
                             checked, exp, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    t_in  in_word;
    t_out out_word;

    pmachine_board board;
    int   idle_cycles;
    int   words_sent;
    bit   timed_out;
    int   op_seen [32];

    pl0_register_pmachine_execute u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: stall pattern of its own, with calm stretches
    initial begin
        int phase;
        out_stall = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if ((phase / 300) % 3 == 2) out_stall <= 0;
            else out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // score results and accepted words at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && board != null) begin
            if (out_valid && !out_stall) board.check_result(out_word);
            if (in_valid && !in_stall) board.note_word(in_word);
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: too long with no word moving
    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("tb: watchdog expired, nothing accepted for %0d cycles", WDOG_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    // present one word and hold it until taken
    task automatic send_word(t_in w);
        in_word <= w;
        in_valid <= 1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        op_seen[w.opcode]++;
        words_sent++;
        @(negedge i_clk);
    endtask

    // a gap with valid low, its length set by n; no gap keeps words back to back
    task automatic drop_valid_and_gap(int n);
        if (n > 0) begin
            in_valid <= 0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    function automatic t_in mk(t_op op, int r, int l, logic [31:0] m, logic [31:0] rd = 0);
        t_in w;
        w.opcode = op;
        w.reg_sel = 3'(r);
        w.level_or_src = 4'(l);
        w.operand_m = m;
        w.read_value = rd;
        return w;
    endfunction

    // random operand m that mostly lands in useful ranges
    function automatic logic [31:0] rnd_m(logic [4:0] op);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
            2: return -$urandom_range(0, 8);
            default: begin
                case (op)
                    OP_SYS: return $urandom_range(0, 4);
                    OP_INC: return $signed($urandom_range(0, 12)) - 4;
                    OP_LOD, OP_STO: return $signed($urandom_range(0, 10)) - 2;
                    OP_LIT: return $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20);
                    OP_JMP, OP_JPC, OP_CAL: return $urandom_range(0, 1023);
                    default: return $urandom_range(0, 7);
                endcase
            end
        endcase
    endfunction

    function automatic t_in rnd_word();
        t_in w;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) w.opcode = 5'($urandom_range(23, 31));
        else if (pick < 6) w.opcode = OP_NOP;
        else if (pick < 7) w.opcode = OP_SYS;
        else w.opcode = 5'($urandom_range(1, 22));
        w.reg_sel = 3'($urandom_range(0, 7));
        w.level_or_src = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 2));
        w.operand_m = rnd_m(w.opcode);
        // halt would freeze the machine; keep it rare in the random part
        if (w.opcode == OP_SYS && w.operand_m == SYS_HALT && $urandom_range(0, 3) != 0)
            w.operand_m = SYS_WRITE;
        w.read_value = $urandom();
        return w;
    endfunction

    task automatic wait_drained();
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_in w;
        int  burst, i, ops_hit;
        board = new();
        in_valid = 0;
        in_word = '0;
        i_rst_n = 0;
        idle_cycles = 0;
        words_sent = 0;
        timed_out = 0;
        foreach (op_seen[k]) op_seen[k] = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: field extremes, every op, faults and frame handling
        send_word(mk(OP_LIT, 0, 0, 32'h8000_0000));
        send_word(mk(OP_LIT, 1, 0, 32'hffff_ffff));
        send_word(mk(OP_DIV, 2, 0, 1));                 // most negative over -1
        send_word(mk(OP_MOD, 3, 0, 1));
        send_word(mk(OP_DIV, 4, 0, 5));                 // divide by zero
        send_word(mk(OP_MOD, 4, 1, 6));                 // modulo by zero
        send_word(mk(OP_ODD, 1, 0, 0));                 // negative odd gives -1
        send_word(mk(OP_LIT, 7, 15, 32'h7fff_ffff));
        send_word(mk(OP_SYS, 5, 0, SYS_READ, 32'hdead_beef));
        send_word(mk(OP_SYS, 5, 0, SYS_WRITE));
        send_word(mk(OP_SYS, 7, 0, 32'd77));            // unknown system call
        send_word(mk(OP_INC, 0, 0, 6));
        send_word(mk(OP_STO, 7, 0, 1));
        send_word(mk(OP_LOD, 6, 0, 1));
        send_word(mk(OP_LOD, 6, 0, -1));                // above the stack top
        send_word(mk(OP_LOD, 6, 15, 0));                // link walk fifteen levels deep
        send_word(mk(OP_INC, 0, 0, -1));                // negative inc raises sp
        send_word(mk(OP_CAL, 0, 0, 32'hffff_ffff));
        send_word(mk(OP_STO, 7, 1, 2));
        send_word(mk(OP_RTN, 0, 0, 0));
        send_word(mk(OP_JPC, 2, 0, 40));
        send_word(mk(OP_JMP, 0, 0, 32'd600));
        for (i = 10; i <= 22; i++) send_word(mk(t_op'(i), i % 8, i % 8, i + 1));
        send_word(mk(t_op'(31), 7, 15, 32'hffff_ffff, 32'hffff_ffff));

        // drain everything before going random
        drop_valid_and_gap(1);
        wait_drained();

        // random part: bursts of words with gaps of random length
        i = 0;
        while (i < N_RANDOM) begin
            burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            while (burst > 0 && i < N_RANDOM) begin
                w = rnd_word();
                // every so often a call is followed by a proper return sequence
                if (w.opcode == OP_CAL && $urandom_range(0, 1)) begin
                    send_word(w);
                    send_word(mk(OP_INC, 0, 0, $urandom_range(0, 3)));
                    send_word(mk(OP_STO, $urandom_range(0, 7), $urandom_range(0, 1),
                                 $urandom_range(0, 3)));
                    send_word(mk(OP_RTN, 0, 0, 0));
                    i += 4;
                end else begin
                    send_word(w);
                    i++;
                end
                burst--;
            end
            if (i > N_RANDOM / 2 && i < N_RANDOM / 2 + 50) begin
                drop_valid_and_gap(1);
                wait_drained();
            end
            drop_valid_and_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
        end
        // final halt so the frozen state is checked too
        send_word(mk(OP_SYS, 0, 0, SYS_HALT));
        send_word(mk(OP_LIT, 3, 0, 99));
        drop_valid_and_gap(1);

        wait_drained();
        repeat (60) @(negedge i_clk);

        ops_hit = 0;
        for (i = 1; i <= 22; i++) if (op_seen[i] != 0) ops_hit++;
        $display("tb: %0d words sent, %0d results checked, %0d of 22 ops exercised",
                 words_sent, board.checked, ops_hit);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: %0d mismatches, %0d results missing",
                     board.mismatches, board.pending.size());
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/pl0rpm_pkg.sv
hw/rtl/pl0rpm_div.sv
hw/rtl/pl0rpm_front.sv
hw/rtl/pl0rpm_back.sv
hw/rtl/pl0_register_pmachine_execute.sv
dv/tb.sv
